### rtl/rclt_pkg.sv
// ----------------------------------------------------------------------------
// rclt_pkg
// Shared constants and types for the reference-counted lookup table.
// ----------------------------------------------------------------------------
package rclt_pkg;

  localparam int SLOTS          = 32;
  localparam int COUNT_BITS     = 16;
  localparam int NUM_BITS       = 32;
  localparam int SLOT_BITS      = $clog2(SLOTS);
  localparam int FREE_BITS      = 5;
  localparam int IDX_FIELD_BITS = 5;
  localparam int REF_FIELD_BITS = 16;
  localparam int QDEPTH         = 2;
  localparam int QPTR_BITS      = $clog2(QDEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_ALLOC = 2'd1,
    ST_FULL  = 2'd2,
    ST_FREED = 2'd3
  } status_t;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FREE   = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_FREE,
    CMD_FREE_SKIP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [NUM_BITS-1:0]    number;
    logic [FREE_BITS-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_WRITE
  } back_state_t;

endpackage

### rtl/rclt_front.sv
// ----------------------------------------------------------------------------
// rclt_front
// Accepts requests and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module rclt_front import rclt_pkg::*; (
  input  logic                 start,
  input  logic                 busy,
  input  logic                 req_type,
  input  logic [NUM_BITS-1:0]  object_number,
  input  logic [FREE_BITS-1:0] slot_to_free,
  output logic                 push,
  output cmd_t                 cmd
);

  logic in_range;

  assign in_range = (32'(slot_to_free) < SLOTS);
  assign push     = start && !busy;

  always_comb begin
    cmd.number = object_number;
    cmd.slot   = slot_to_free;
    if (req_type == REQ_FREE) begin
      // A free beyond the table still reports, but touches nothing.
      cmd.kind = in_range ? CMD_FREE : CMD_FREE_SKIP;
    end else begin
      cmd.kind = CMD_LOOKUP;
    end
  end

endmodule

### rtl/rclt_queue.sv
// ----------------------------------------------------------------------------
// rclt_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rclt_queue import rclt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t stat
);

  cmd_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/rclt_back.sv
// ----------------------------------------------------------------------------
// rclt_back
// Carries out commands: owns the slot memory, scans it, writes back, reports.
// ----------------------------------------------------------------------------
module rclt_back import rclt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  q_status_t                 q_stat,
  input  cmd_t                      q_cmd,
  output logic                      q_pop,
  output logic                      done,
  output logic [1:0]                status,
  output logic [IDX_FIELD_BITS-1:0] slot_index,
  output logic [REF_FIELD_BITS-1:0] reference_count
);

  // Slot memory, with one valid bit per slot so that reset empties it at once.
  logic [NUM_BITS-1:0]   mem_num [SLOTS];
  logic [COUNT_BITS-1:0] mem_cnt [SLOTS];
  logic [SLOTS-1:0]      valid;

  logic [NUM_BITS-1:0]   rd_num_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic                  rd_vld_q;
  logic [NUM_BITS-1:0]   rd_num;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic                  rd_en;
  logic [SLOT_BITS-1:0]  rd_addr;
  logic                  wr_en;
  logic                  wr_clear;
  logic [SLOT_BITS-1:0]  wr_addr;
  logic [NUM_BITS-1:0]   wr_num;
  logic [COUNT_BITS-1:0] wr_cnt;

  back_state_t           state, state_next;
  cmd_t                  cmd, cmd_next;
  logic [SLOT_BITS:0]    issue_cnt, issue_cnt_next;
  logic                  rd_live, rd_live_next;
  logic [SLOT_BITS-1:0]  rd_idx, rd_idx_next;
  logic                  have_free, have_free_next;
  logic [SLOT_BITS-1:0]  free_idx, free_idx_next;
  logic                  hit, hit_next;
  logic [SLOT_BITS-1:0]  hit_idx, hit_idx_next;
  logic [COUNT_BITS-1:0] hit_cnt, hit_cnt_next;

  logic                      done_next;
  logic [1:0]                status_next;
  logic [IDX_FIELD_BITS-1:0] slot_index_next;
  logic [REF_FIELD_BITS-1:0] reference_count_next;

  assign rd_num = rd_vld_q ? rd_num_q : '0;
  assign rd_cnt = rd_vld_q ? rd_cnt_q : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_num_q <= mem_num[rd_addr];
      rd_cnt_q <= mem_cnt[rd_addr];
    end
    if (wr_en && !wr_clear) begin
      mem_num[wr_addr] <= wr_num;
      mem_cnt[wr_addr] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= valid[rd_addr];
      end
      if (wr_en) begin
        valid[wr_addr] <= !wr_clear;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      rd_live <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_live <= rd_live_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd             <= cmd_next;
    issue_cnt       <= issue_cnt_next;
    rd_idx          <= rd_idx_next;
    have_free       <= have_free_next;
    free_idx        <= free_idx_next;
    hit             <= hit_next;
    hit_idx         <= hit_idx_next;
    hit_cnt         <= hit_cnt_next;
    status          <= status_next;
    slot_index      <= slot_index_next;
    reference_count <= reference_count_next;
  end

  always_comb begin
    state_next           = state;
    cmd_next             = cmd;
    issue_cnt_next       = issue_cnt;
    rd_live_next         = rd_live;
    rd_idx_next          = rd_idx;
    have_free_next       = have_free;
    free_idx_next        = free_idx;
    hit_next             = hit;
    hit_idx_next         = hit_idx;
    hit_cnt_next         = hit_cnt;
    done_next            = 1'b0;
    status_next          = status;
    slot_index_next      = slot_index;
    reference_count_next = reference_count;
    q_pop                = 1'b0;
    rd_en                = 1'b0;
    rd_addr              = issue_cnt[SLOT_BITS-1:0];
    wr_en                = 1'b0;
    wr_clear             = 1'b0;
    wr_addr              = hit_idx;
    wr_num               = cmd.number;
    wr_cnt               = hit_cnt;

    case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop    = 1'b1;
          cmd_next = q_cmd;
          case (q_cmd.kind)
            CMD_FREE: begin
              wr_en                = 1'b1;
              wr_clear             = 1'b1;
              wr_addr              = SLOT_BITS'(q_cmd.slot);
              done_next            = 1'b1;
              status_next          = ST_FREED;
              slot_index_next      = IDX_FIELD_BITS'(q_cmd.slot);
              reference_count_next = '0;
            end
            CMD_FREE_SKIP: begin
              done_next            = 1'b1;
              status_next          = ST_FREED;
              slot_index_next      = IDX_FIELD_BITS'(q_cmd.slot);
              reference_count_next = '0;
            end
            CMD_LOOKUP: begin
              state_next     = B_SCAN;
              issue_cnt_next = '0;
              rd_live_next   = 1'b0;
              have_free_next = 1'b0;
              free_idx_next  = '0;
            end
            default: begin
              state_next = B_IDLE;
            end
          endcase
        end
      end

      B_SCAN: begin
        // Reads are issued one slot ahead of the compare on the returned data.
        rd_live_next = 1'b0;
        if (issue_cnt < (SLOT_BITS+1)'(SLOTS)) begin
          rd_en          = 1'b1;
          issue_cnt_next = issue_cnt + 1'b1;
          rd_live_next   = 1'b1;
          rd_idx_next    = issue_cnt[SLOT_BITS-1:0];
        end
        if (rd_live) begin
          if (rd_num == cmd.number) begin
            hit_next     = 1'b1;
            hit_idx_next = rd_idx;
            hit_cnt_next = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
            state_next   = B_WRITE;
          end else begin
            if (!have_free && rd_cnt == '0) begin
              have_free_next = 1'b1;
              free_idx_next  = rd_idx;
            end
            if (rd_idx == SLOT_BITS'(SLOTS - 1)) begin
              hit_next   = 1'b0;
              state_next = B_WRITE;
            end
          end
        end
      end

      B_WRITE: begin
        state_next = B_IDLE;
        done_next  = 1'b1;
        if (hit) begin
          wr_en                = 1'b1;
          status_next          = ST_HIT;
          slot_index_next      = IDX_FIELD_BITS'(hit_idx);
          reference_count_next = REF_FIELD_BITS'(hit_cnt);
        end else if (have_free) begin
          wr_en                = 1'b1;
          wr_addr              = free_idx;
          wr_cnt               = COUNT_BITS'(1);
          status_next          = ST_ALLOC;
          slot_index_next      = IDX_FIELD_BITS'(free_idx);
          reference_count_next = REF_FIELD_BITS'(1);
        end else begin
          status_next          = ST_FULL;
          slot_index_next      = '0;
          reference_count_next = '0;
        end
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

endmodule

### rtl/refcounted_lookup_allocate_table_unit.sv
// ----------------------------------------------------------------------------
// refcounted_lookup_allocate_table_unit
// Reference-counted slot table: lookup with allocate on miss, and free.
// ----------------------------------------------------------------------------
// A lookup in the back part pops the command, reads the slots in order and
// compares each entry one slot behind its read, then writes back; a hit ends
// the scan early. A free completes as it is popped. The single read port of
// the slot memory sets the lookup rate. Requests queue two deep; busy is high
// while full. Synchronous reset empties the queue and the whole table at once.
module refcounted_lookup_allocate_table_unit import rclt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic [NUM_BITS-1:0]       object_number,
  input  logic [FREE_BITS-1:0]      slot_to_free,
  output logic                      done,
  output logic [1:0]                status,
  output logic [IDX_FIELD_BITS-1:0] slot_index,
  output logic [REF_FIELD_BITS-1:0] reference_count
);

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_stat;

  assign busy = q_stat.full;

  rclt_front u_front (
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .object_number (object_number),
    .slot_to_free  (slot_to_free),
    .push          (push),
    .cmd           (push_cmd)
  );

  rclt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  rclt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_stat          (q_stat),
    .q_cmd           (head),
    .q_pop           (pop),
    .done            (done),
    .status          (status),
    .slot_index      (slot_index),
    .reference_count (reference_count)
  );

endmodule

### rtl/rclt_checker.sv
// ----------------------------------------------------------------------------
// rclt_checker
// Port-level checks on the lookup table's results, bound to the top level.
// ----------------------------------------------------------------------------
module rclt_checker import rclt_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      busy,
  input logic                      done,
  input logic [1:0]                status,
  input logic [IDX_FIELD_BITS-1:0] slot_index,
  input logic [REF_FIELD_BITS-1:0] reference_count
);

  // Reset empties both the queue and the back part.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy high right after reset");

  // A full table reports no slot and no count.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> slot_index == '0 && reference_count == '0)
    else $error("full result carries a slot or count");

  // A fresh allocation always starts at one reference.
  a_alloc_one: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_ALLOC |-> reference_count == REF_FIELD_BITS'(1))
    else $error("allocation count is not one");

  // A hit has just been incremented or saturated, so it is never zero.
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_HIT |-> reference_count != '0)
    else $error("hit with zero count");

  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FREED |-> reference_count == '0)
    else $error("free result carries a count");

endmodule

bind refcounted_lookup_allocate_table_unit rclt_checker u_rclt_checker (.*);

### tb/refcounted_lookup_allocate_table_unit_tb.sv
// ----------------------------------------------------------------------------
// refcounted_lookup_allocate_table_unit_tb
// Self-checking bench for the reference-counted slot table. A short table of
// lookups and frees covers empty slots, a full table and the hit paths. The
// table is then emptied, and random traffic from a small pool of object
// numbers follows. Every done beat is compared, field by field, with a written
// reply or with one from a local model of the table.
// ----------------------------------------------------------------------------
module refcounted_lookup_allocate_table_unit_tb;
  import rclt_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_BEATS = 700;
  localparam int CALM_BEATS   = 120;
  localparam int POOL_SIZE    = 40;
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 3) + 8;

  typedef struct packed {
    status_t                   status;
    logic [IDX_FIELD_BITS-1:0] idx;
    logic [REF_FIELD_BITS-1:0] cnt;
  } reply_t;

  typedef struct {
    logic                 rt;
    logic [NUM_BITS-1:0]  num;
    logic [FREE_BITS-1:0] sl;
    bit                   typed;
    reply_t               want;
  } beat_row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      req_type;
  logic [NUM_BITS-1:0]       object_number;
  logic [FREE_BITS-1:0]      slot_to_free;
  logic                      done;
  logic [1:0]                status;
  logic [IDX_FIELD_BITS-1:0] slot_index;
  logic [REF_FIELD_BITS-1:0] reference_count;

  logic [NUM_BITS-1:0]   model_numbers [SLOTS];
  logic [COUNT_BITS-1:0] model_counts  [SLOTS];
  reply_t                pending_replies [$];
  beat_row_t             dir_rows [$];
  logic [NUM_BITS-1:0]   number_pool [POOL_SIZE];
  int                    error_count = 0;
  int                    cycle_count = 0;

  refcounted_lookup_allocate_table_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .object_number   (object_number),
    .slot_to_free    (slot_to_free),
    .done            (done),
    .status          (status),
    .slot_index      (slot_index),
    .reference_count (reference_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one request to the local copy of the table and returns its reply.
  function automatic reply_t table_apply(input logic rt, input logic [NUM_BITS-1:0] num,
                                         input logic [FREE_BITS-1:0] sl);
    reply_t r;
    int     free_at;
    r.status = ST_FREED;
    r.idx    = sl;
    r.cnt    = '0;
    free_at  = -1;
    if (rt == REQ_FREE) begin
      if (int'(sl) < SLOTS) begin
        model_numbers[sl] = '0;
        model_counts[sl]  = '0;
      end
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (model_numbers[i] == num) begin
        if (model_counts[i] != COUNT_MAX) model_counts[i] = model_counts[i] + 1'b1;
        r.status = ST_HIT;
        r.idx    = IDX_FIELD_BITS'(i);
        r.cnt    = REF_FIELD_BITS'(model_counts[i]);
        return r;
      end
      if (free_at < 0 && model_counts[i] == '0) free_at = i;
    end
    if (free_at < 0) begin
      r.status = ST_FULL;
      r.idx    = '0;
      return r;
    end
    model_numbers[free_at] = num;
    model_counts[free_at]  = COUNT_BITS'(1);
    r.status = ST_ALLOC;
    r.idx    = IDX_FIELD_BITS'(free_at);
    r.cnt    = REF_FIELD_BITS'(1);
    return r;
  endfunction

  function automatic void add_row(input logic rt, input logic [NUM_BITS-1:0] num,
                                  input logic [FREE_BITS-1:0] sl, input bit typed,
                                  input status_t st, input int idx, input int cnt);
    beat_row_t row;
    row.rt          = rt;
    row.num         = num;
    row.sl          = sl;
    row.typed       = typed;
    row.want.status = st;
    row.want.idx    = IDX_FIELD_BITS'(idx);
    row.want.cnt    = REF_FIELD_BITS'(cnt);
    dir_rows.push_back(row);
  endfunction

  // Presents one request from the next falling edge and holds it until accepted.
  task automatic send_beat(input logic rt, input logic [NUM_BITS-1:0] num,
                           input logic [FREE_BITS-1:0] sl, input bit typed,
                           input reply_t want);
    reply_t r;
    @(negedge clk);
    start         <= 1'b1;
    req_type      <= rt;
    object_number <= num;
    slot_to_free  <= sl;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = table_apply(rt, num, sl);
    pending_replies.push_back(typed ? want : r);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected done beat: status %0d slot_index %0d reference_count %0d",
               status, slot_index, reference_count);
        error_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          error_count++;
        end
        if (slot_index !== exp_r.idx) begin
          $error("slot_index: expected %0d, got %0d", exp_r.idx, slot_index);
          error_count++;
        end
        if (reference_count !== exp_r.cnt) begin
          $error("reference_count: expected %0d, got %0d", exp_r.cnt, reference_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    reply_t    none;
    beat_row_t row;
    int        free_pct;
    logic      rt;
    logic [NUM_BITS-1:0] num;

    none          = '0;
    rst           = 1'b1;
    start         = 1'b0;
    req_type      = REQ_LOOKUP;
    object_number = '0;
    slot_to_free  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      model_numbers[i] = '0;
      model_counts[i]  = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Cleared slots hold number zero, so zero hits slot 0 whatever its count.
    add_row(REQ_LOOKUP, 32'h0000_0000, 5'd31, 1, ST_HIT,   0, 1);
    add_row(REQ_LOOKUP, 32'h0000_0000, 5'd0,  1, ST_HIT,   0, 2);
    add_row(REQ_LOOKUP, 32'hFFFF_FFFF, 5'd31, 1, ST_ALLOC, 1, 1);
    add_row(REQ_LOOKUP, 32'hFFFF_FFFF, 5'd0,  1, ST_HIT,   1, 2);
    add_row(REQ_LOOKUP, 32'h0000_0001, 5'd15, 1, ST_ALLOC, 2, 1);
    add_row(REQ_LOOKUP, 32'h8000_0000, 5'd16, 1, ST_ALLOC, 3, 1);
    add_row(REQ_FREE,   32'hFFFF_FFFF, 5'd31, 1, ST_FREED, 31, 0);
    add_row(REQ_FREE,   32'h0000_0000, 5'd0,  1, ST_FREED, 0, 0);
    add_row(REQ_LOOKUP, 32'h0000_0000, 5'd31, 1, ST_HIT,   0, 1);
    add_row(REQ_FREE,   32'h1234_5678, 5'd0,  1, ST_FREED, 0, 0);
    add_row(REQ_LOOKUP, 32'hA5A5_A5A5, 5'd10, 1, ST_ALLOC, 0, 1);
    add_row(REQ_LOOKUP, 32'h0000_0000, 5'd21, 1, ST_HIT,   4, 1);
    add_row(REQ_FREE,   32'h0000_0000, 5'd2,  1, ST_FREED, 2, 0);
    add_row(REQ_LOOKUP, 32'h0000_0001, 5'd7,  1, ST_ALLOC, 2, 1);
    add_row(REQ_LOOKUP, 32'h5A5A_5A5A, 5'd3,  0, ST_HIT,   0, 0);
    // Fill every slot; the last lookups find the table full.
    for (int i = 0; i < 32; i++)
      add_row(REQ_LOOKUP, 32'h0001_0000 + i, 5'(i), 0, ST_HIT, 0, 0);
    add_row(REQ_FREE,   32'h0000_0000, 5'd4,  1, ST_FREED, 4, 0);
    add_row(REQ_LOOKUP, 32'h0002_0000, 5'd9,  1, ST_ALLOC, 4, 1);
    add_row(REQ_LOOKUP, 32'h0000_0000, 5'd0,  1, ST_FULL,  0, 0);
    add_row(REQ_LOOKUP, 32'hFFFF_FFFE, 5'd31, 1, ST_FULL,  0, 0);
    add_row(REQ_LOOKUP, 32'hFFFF_FFFF, 5'd0,  1, ST_HIT,   1, 3);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_beat(row.rt, row.num, row.sl, row.typed, row.want);
    end

    // Empty the table before the random traffic.
    for (int i = 0; i < SLOTS; i++)
      send_beat(REQ_FREE, $urandom, 5'(i), 0, none);
    wait_drained();

    for (int i = 0; i < POOL_SIZE; i++)
      number_pool[i] = (i == 0) ? 32'h0 : $urandom;
    free_pct = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: begin free_pct = 0;  end
          1: begin free_pct = 5;  end
          2: begin free_pct = 25; end
          default: begin free_pct = 50; end
        endcase
      end
      if (n == RANDOM_BEATS / 2) wait_drained();
      if (n < RANDOM_BEATS - CALM_BEATS && $urandom_range(0, 4) == 0)
        hold_off($urandom_range(1, 14));
      rt = ($urandom_range(0, 99) < free_pct) ? REQ_FREE : REQ_LOOKUP;
      if (rt == REQ_LOOKUP && $urandom_range(0, 9) != 0)
        num = number_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        num = $urandom;
      send_beat(rt, num, 5'($urandom_range(0, 31)), 0, none);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
